>>> sv/hksa_pkg.sv
// Package for the hashed key score accumulator: sizes, command and status codes,
// and the sequencer state type. No dependencies.
`default_nettype none
package hksa_pkg;
    localparam int NumBuckets = 101;
    localparam int Capacity   = 64;
    localparam int NameBytes  = 32;
    localparam int Chunks     = 4;
    localparam int BktW       = 7;   // bucket index, also holds NumBuckets
    localparam int EntW       = 6;   // entry index
    localparam int PtrW       = 7;   // entry pointer with empty marker
    localparam int CntW       = 7;   // entries used, holds Capacity
    localparam logic [PtrW-1:0] Nil = 7'h7f;

    // quotient by NumBuckets as (x * HashRecip) >> HashShift, exact for x < 2^17
    localparam int HashRecip  = 20764;
    localparam int HashShift  = 21;

    typedef enum logic [1:0] {
        t_cmd_load = 2'd0, t_cmd_add = 2'd1, t_cmd_read = 2'd2, t_cmd_restart = 2'd3
    } t_cmd;

    localparam logic [2:0] StNew    = 3'd0;
    localparam logic [2:0] StMerged = 3'd1;
    localparam logic [2:0] StFull   = 3'd2;
    localparam logic [2:0] StData   = 3'd3;
    localparam logic [2:0] StDone   = 3'd4;

    typedef enum logic [3:0] {
        t_idle, t_clear, t_hash, t_head, t_walk, t_cmp, t_append, t_link,
        t_rscan, t_rhead, t_rdata, t_out
    } t_state;
endpackage
`default_nettype wire

>>> sv/hashed_key_score_accumulator.sv
// Hashed key score accumulator top level: group-by-sum table with chained buckets.
// Depends on hksa_pkg.
//
// Usage: one input stream (s_axis) carries commands, one output stream (m_axis)
// carries results. Load (0) and restart (3) give no result.
// Add (1) hashes the 32-byte name one byte per cycle through a shared
// multiply-add / modulo step, reads the bucket head, then walks the chain
// comparing one name chunk per cycle, and gives one result. Read (2) scans
// the buckets past empty ones and then gives four results, one per name chunk,
// tlast on the fourth, or one done result with tlast once every bucket is past.
// Each table has one read port and one write port.
// After reset a clearing pass marks every bucket empty; no item is accepted
// meanwhile. Results sit in an output register; while the receiver stalls the
// sequencer gives no further result and s_axis_tready stays low.
`default_nettype none
module hashed_key_score_accumulator (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: command[1:0], chunk_index[3:2], key_chunk[67:4], score[99:68], zero[103:100]
    input  wire logic [103:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: status[2:0], name_chunk[66:3], out_chunk_index[68:67], total_score[100:69],
    // zero[103:101]
    output logic [103:0]      m_axis_tdata,
    output logic              m_axis_tlast
);
    localparam int BW = hksa_pkg::BktW;
    localparam int EW = hksa_pkg::EntW;
    localparam int PW = hksa_pkg::PtrW;

    hksa_pkg::t_state r_state, n_state;

    logic [63:0] r_key [hksa_pkg::Chunks];
    logic [63:0] r_name_mem [hksa_pkg::Capacity*hksa_pkg::Chunks];
    logic [31:0] r_total_mem [hksa_pkg::Capacity];
    logic [PW-1:0] r_link_mem [hksa_pkg::Capacity];
    logic [PW-1:0] r_head_mem [hksa_pkg::NumBuckets];

    logic [BW-1:0] r_cnt, n_cnt;     // clear address / hash byte count
    logic [BW-1:0] r_hash, n_hash;
    logic [BW-1:0] r_rbkt, n_rbkt;
    logic [PW-1:0] r_rent, n_rent;
    logic [PW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_tail, n_tail;
    logic [hksa_pkg::CntW-1:0] r_used, n_used;
    logic [1:0]  r_k, n_k;
    logic        r_mis, n_mis;
    logic [31:0] r_score, n_score;

    // registered memory reads
    logic [63:0]   r_name_q;
    logic [31:0]   r_total_q;
    logic [PW-1:0] r_link_q;
    logic [PW-1:0] r_head_q;

    // output register
    logic          r_ovalid, n_ovalid;
    logic [2:0]    r_ost, n_ost;
    logic [63:0]   r_onc, n_onc;
    logic [1:0]    r_oci, n_oci;
    logic [31:0]   r_otot, n_otot;
    logic          r_olast, n_olast;

    // memory control
    logic          head_we;
    logic [BW-1:0] head_wa, head_ra;
    logic [PW-1:0] head_wd;
    logic [EW+1:0] name_ra;
    logic [EW-1:0] ent_ra;
    logic          tot_we, link_we, name_we;
    logic [EW-1:0] tot_wa, link_wa;
    logic [31:0]   tot_wd;
    logic [PW-1:0] link_wd;

    logic [1:0]  in_cmd, in_ci;
    logic [63:0] in_chunk, in_chunk_m;
    logic [31:0] in_score;
    logic        in_acc;
    logic [7:0]  hbyte;
    logic [14:0] hsum;
    logic [29:0] hprod;
    logic [7:0]  hquo;
    logic [BW-1:0] hmod;
    logic [63:0] cur_key;

    assign in_cmd   = s_axis_tdata[1:0];
    assign in_ci    = s_axis_tdata[3:2];
    assign in_chunk = s_axis_tdata[67:4];
    assign in_score = s_axis_tdata[99:68];
    assign s_axis_tready = (r_state == hksa_pkg::t_idle) && !r_ovalid;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // zero bytes past the end of the name
    always_comb begin
        in_chunk_m = in_chunk;
        for (int j = 0; j < 8; j++) begin
            if (32'(in_ci) * 8 + j >= hksa_pkg::NameBytes)
                in_chunk_m[56-8*j +: 8] = 8'h00;
        end
    end

    // shared hash step: h*128 + byte, reduced mod 101 (h < 101 so sum < 13184);
    // take the quotient by reciprocal multiply, then subtract its multiple
    assign cur_key = r_key[r_cnt[4:3]];
    always_comb begin
        hbyte = 8'h00;
        if (32'(r_cnt) < hksa_pkg::NameBytes && r_cnt < 7'(hksa_pkg::Chunks*8))
            hbyte = cur_key[56-8*r_cnt[2:0] +: 8];
        hsum  = 15'({r_hash, 7'd0}) + 15'(hbyte);
        hprod = 30'(hsum) * 30'(hksa_pkg::HashRecip);
        hquo  = 8'(hprod >> hksa_pkg::HashShift);
        hmod  = 7'(hsum - 15'(hquo) * 15'(hksa_pkg::NumBuckets));
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt; n_hash = r_hash; n_rbkt = r_rbkt; n_rent = r_rent;
        n_cur = r_cur; n_tail = r_tail; n_used = r_used; n_k = r_k; n_mis = r_mis;
        n_score = r_score;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_ost = r_ost; n_onc = r_onc; n_oci = r_oci; n_otot = r_otot; n_olast = r_olast;
        head_we = 1'b0; head_wa = r_cnt; head_wd = hksa_pkg::Nil; head_ra = r_hash;
        name_ra = {r_cur[EW-1:0], r_k}; ent_ra = r_cur[EW-1:0];
        tot_we = 1'b0; tot_wa = r_cur[EW-1:0]; tot_wd = r_total_q + r_score;
        link_we = 1'b0; link_wa = r_tail[EW-1:0]; link_wd = r_cur;
        name_we = 1'b0;
        unique case (r_state)
            hksa_pkg::t_clear: begin
                head_we = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (32'(r_cnt) == hksa_pkg::NumBuckets - 1) n_state = hksa_pkg::t_idle;
            end
            hksa_pkg::t_idle: begin
                if (in_acc) begin
                    unique case (hksa_pkg::t_cmd'(in_cmd))
                        hksa_pkg::t_cmd_load: ;
                        hksa_pkg::t_cmd_restart: begin
                            n_rbkt = '0; n_rent = hksa_pkg::Nil;
                        end
                        hksa_pkg::t_cmd_add: begin
                            n_score = in_score; n_cnt = '0; n_hash = '0;
                            n_state = hksa_pkg::t_hash;
                        end
                        hksa_pkg::t_cmd_read: begin
                            if (r_rent == hksa_pkg::Nil) begin
                                n_state = hksa_pkg::t_rscan;
                            end else begin
                                n_cur = r_rent; n_k = '0; n_state = hksa_pkg::t_rhead;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            hksa_pkg::t_hash: begin
                n_hash = hmod;
                n_cnt = r_cnt + 7'd1;
                if (32'(r_cnt) == hksa_pkg::NameBytes - 1) n_state = hksa_pkg::t_head;
            end
            hksa_pkg::t_head: begin
                // head read issued at head_ra = r_hash; result next cycle
                n_tail = hksa_pkg::Nil; n_cur = hksa_pkg::Nil; n_k = '0;
                n_state = hksa_pkg::t_walk;
            end
            hksa_pkg::t_walk: begin
                // r_head_q or r_link_q holds the next pointer
                n_cur = (r_tail == hksa_pkg::Nil) ? r_head_q : r_link_q;
                n_k = '0; n_mis = 1'b0;
                if (n_cur == hksa_pkg::Nil) n_state = hksa_pkg::t_append;
                else n_state = hksa_pkg::t_cmp;
                name_ra = {n_cur[EW-1:0], 2'd0};
                ent_ra = n_cur[EW-1:0];
            end
            hksa_pkg::t_cmp: begin
                // r_name_q holds chunk r_k of entry r_cur
                name_ra = {r_cur[EW-1:0], r_k + 2'd1};
                n_mis = r_mis || (r_name_q != r_key[r_k]);
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    if (!n_mis) begin
                        if (!r_ovalid || m_axis_tready) begin
                            tot_we = 1'b1;
                            n_ovalid = 1'b1; n_ost = hksa_pkg::StMerged; n_onc = '0;
                            n_oci = '0; n_otot = tot_wd; n_olast = 1'b1;
                            n_state = hksa_pkg::t_idle;
                        end else begin
                            n_k = r_k; n_mis = r_mis;
                            name_ra = {r_cur[EW-1:0], r_k};
                        end
                    end else begin
                        n_tail = r_cur;
                        n_state = hksa_pkg::t_walk;
                    end
                end
            end
            hksa_pkg::t_append: begin
                if (32'(r_used) >= hksa_pkg::Capacity) begin
                    n_ovalid = 1'b1; n_ost = hksa_pkg::StFull; n_onc = '0; n_oci = '0;
                    n_otot = '0; n_olast = 1'b1; n_state = hksa_pkg::t_idle;
                end else begin
                    n_cur = r_used; n_k = '0; n_state = hksa_pkg::t_link;
                end
            end
            hksa_pkg::t_link: begin
                name_we = 1'b1;
                n_k = r_k + 2'd1;
                if (r_k == 2'd0) begin
                    // terminate the new entry's chain
                    link_we = 1'b1; link_wa = r_cur[EW-1:0]; link_wd = hksa_pkg::Nil;
                end
                if (r_k == 2'd3) begin
                    tot_we = 1'b1; tot_wd = r_score;
                    if (r_tail == hksa_pkg::Nil) begin
                        head_we = 1'b1; head_wa = r_hash; head_wd = r_cur;
                    end else begin
                        // hook the new entry onto the chain tail
                        link_we = 1'b1;
                    end
                    n_used = r_used + 7'd1;
                    n_ovalid = 1'b1; n_ost = hksa_pkg::StNew; n_onc = '0; n_oci = '0;
                    n_otot = r_score; n_olast = 1'b1; n_state = hksa_pkg::t_idle;
                end
            end
            hksa_pkg::t_rscan: begin
                head_ra = r_rbkt;
                if (32'(r_rbkt) >= hksa_pkg::NumBuckets) begin
                    n_rbkt = 7'(hksa_pkg::NumBuckets);
                    n_ovalid = 1'b1; n_ost = hksa_pkg::StDone; n_onc = '0; n_oci = '0;
                    n_otot = '0; n_olast = 1'b1; n_state = hksa_pkg::t_idle;
                end else begin
                    n_state = hksa_pkg::t_rhead;
                    n_cur = hksa_pkg::Nil;
                end
            end
            hksa_pkg::t_rhead: begin
                if (r_cur == hksa_pkg::Nil) begin
                    if (r_head_q == hksa_pkg::Nil) begin
                        n_rbkt = r_rbkt + 7'd1; n_state = hksa_pkg::t_rscan;
                    end else begin
                        n_cur = r_head_q; n_rent = r_head_q;
                    end
                end else begin
                    n_k = '0; n_state = hksa_pkg::t_rdata;
                end
                name_ra = {n_cur[EW-1:0], 2'd0};
                ent_ra = n_cur[EW-1:0];
            end
            hksa_pkg::t_rdata: begin
                name_ra = {r_cur[EW-1:0], r_k};
                ent_ra = r_cur[EW-1:0];
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1; n_ost = hksa_pkg::StData; n_onc = r_name_q;
                    n_oci = r_k; n_otot = r_total_q; n_olast = (r_k == 2'd3);
                    n_k = r_k + 2'd1;
                    name_ra = {r_cur[EW-1:0], r_k + 2'd1};
                    n_state = hksa_pkg::t_out;
                end
            end
            hksa_pkg::t_out: begin
                // wait here while the next chunk read lands
                name_ra = {r_cur[EW-1:0], r_k};
                ent_ra = r_cur[EW-1:0];
                if (r_k == 2'd0) begin
                    n_rent = r_link_q;
                    if (r_link_q == hksa_pkg::Nil) n_rbkt = r_rbkt + 7'd1;
                    n_state = hksa_pkg::t_idle;
                end else begin
                    n_state = hksa_pkg::t_rdata;
                end
            end
            default: n_state = hksa_pkg::t_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) r_head_mem[head_wa] <= head_wd;
        r_head_q <= r_head_mem[head_ra];
        if (name_we) r_name_mem[{r_cur[EW-1:0], r_k}] <= r_key[r_k];
        r_name_q <= r_name_mem[name_ra];
        if (tot_we) r_total_mem[tot_wa] <= tot_wd;
        r_total_q <= r_total_mem[ent_ra];
        if (link_we) r_link_mem[link_wa] <= link_wd;
        r_link_q <= r_link_mem[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hksa_pkg::t_clear;
            r_cnt <= '0; r_hash <= '0; r_rbkt <= '0; r_rent <= hksa_pkg::Nil;
            r_cur <= hksa_pkg::Nil; r_tail <= hksa_pkg::Nil; r_used <= '0;
            r_k <= '0; r_mis <= 1'b0; r_ovalid <= 1'b0;
            for (int i = 0; i < hksa_pkg::Chunks; i++) r_key[i] <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt; r_hash <= n_hash; r_rbkt <= n_rbkt; r_rent <= n_rent;
            r_cur <= n_cur; r_tail <= n_tail; r_used <= n_used;
            r_k <= n_k; r_mis <= n_mis; r_ovalid <= n_ovalid;
            if (in_acc && hksa_pkg::t_cmd'(in_cmd) == hksa_pkg::t_cmd_load)
                r_key[in_ci] <= in_chunk_m;
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
        r_ost <= n_ost; r_onc <= n_onc; r_oci <= n_oci; r_otot <= n_otot;
        r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {3'd0, r_otot, r_oci, r_onc, r_ost};

    // pool count never exceeds capacity
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= hksa_pkg::Capacity) else $error("entry count overflow");
    // no input taken while a result waits
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready) else $error("accept while result pending");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_ost))
        else $error("result dropped under stall");
endmodule
`default_nettype wire
